>>> hw/rtl/gts_pkg.sv
// Shared types, constants and angle tables for the gait table sequencer.
package gts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_S      = 3'd1,
        MODE_CL     = 3'd2,
        MODE_CR     = 3'd3,
        MODE_MANUAL = 3'd4,
        MODE_AVOID  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CMD   = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [2:0] CMD_S      = 3'd0;
    localparam logic [2:0] CMD_LEFT   = 3'd1;
    localparam logic [2:0] CMD_RIGHT  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_MANUAL = 3'd4;

    localparam logic [2:0] SERVO_TAIL   = 3'd0;
    localparam logic [2:0] SERVO_MIDDLE = 3'd1;
    localparam logic [2:0] SERVO_HEAD   = 3'd2;

    localparam logic [2:0] CFG_S_PERIOD    = 3'd0;
    localparam logic [2:0] CFG_TURN_PERIOD = 3'd1;
    localparam logic [2:0] CFG_TRIGGER     = 3'd2;
    localparam logic [2:0] CFG_RELEASE     = 3'd3;
    localparam logic [2:0] CFG_COOLDOWN    = 3'd4;
    localparam logic [2:0] CFG_SERVO_MIN   = 3'd5;
    localparam logic [2:0] CFG_SERVO_MAX   = 3'd6;

    localparam logic [4:0] S_ROWS    = 5'd12;
    localparam logic [4:0] TURN_ROWS = 5'd16;
    localparam logic [7:0] CENTER_DEG = 8'd90;
    localparam logic [7:0] MAX_DEG    = 8'd180;

    localparam logic [15:0] S_PERIOD_RST    = 16'd50;
    localparam logic [15:0] TURN_PERIOD_RST = 16'd80;
    localparam logic [15:0] TRIGGER_RST     = 16'd200;
    localparam logic [15:0] RELEASE_RST     = 16'd300;
    localparam logic [15:0] COOLDOWN_RST    = 16'd2000;
    localparam logic [7:0]  SERVO_MIN_RST   = 8'd0;
    localparam logic [7:0]  SERVO_MAX_RST   = 8'd180;

    typedef struct packed {
        logic [7:0] tail;
        logic [7:0] middle;
        logic [7:0] head;
    } angles_t;

    localparam angles_t CENTER_ANGLES = {CENTER_DEG, CENTER_DEG, CENTER_DEG};

    typedef struct packed {
        logic [15:0] s_step_period_ms;
        logic [15:0] turn_step_period_ms;
        logic [15:0] obstacle_trigger;
        logic [15:0] obstacle_release;
        logic [15:0] rearm_delay_ms;
        logic [7:0]  servo_min_deg;
        logic [7:0]  servo_max_deg;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] time_ms;
        logic [15:0] distance;
        logic [2:0]  command_code;
        logic [2:0]  servo_id;
        logic [7:0]  angle_deg;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tail_angle;
        logic [7:0] middle_angle;
        logic [7:0] head_angle;
        logic [2:0] current_mode;
        logic       avoid_started;
        logic       write_accepted;
    } out_item_t;

    function automatic angles_t wave_row(input logic [3:0] r);
        angles_t a;
        case (r)
            4'd0:    a = {8'd116, 8'd107, 8'd90};
            4'd1:    a = {8'd105, 8'd110, 8'd95};
            4'd2:    a = {8'd90,  8'd107, 8'd99};
            4'd3:    a = {8'd75,  8'd100, 8'd100};
            4'd4:    a = {8'd64,  8'd90,  8'd99};
            4'd5:    a = {8'd60,  8'd80,  8'd95};
            4'd6:    a = {8'd64,  8'd73,  8'd90};
            4'd7:    a = {8'd75,  8'd70,  8'd85};
            4'd8:    a = {8'd90,  8'd73,  8'd81};
            4'd9:    a = {8'd105, 8'd80,  8'd80};
            4'd10:   a = {8'd116, 8'd90,  8'd81};
            4'd11:   a = {8'd120, 8'd100, 8'd85};
            default: a = CENTER_ANGLES;
        endcase
        return a;
    endfunction

    function automatic angles_t left_row(input logic [3:0] r);
        angles_t a;
        case (r)
            4'd0:    a = {8'd90, 8'd90, 8'd90};
            4'd1:    a = {8'd84, 8'd86, 8'd88};
            4'd2:    a = {8'd78, 8'd82, 8'd86};
            4'd3:    a = {8'd72, 8'd78, 8'd84};
            4'd4:    a = {8'd66, 8'd74, 8'd82};
            4'd5:    a = {8'd60, 8'd70, 8'd80};
            4'd6:    a = {8'd60, 8'd70, 8'd80};
            4'd7:    a = {8'd60, 8'd70, 8'd80};
            4'd8:    a = {8'd60, 8'd70, 8'd80};
            4'd9:    a = {8'd60, 8'd70, 8'd80};
            4'd10:   a = {8'd66, 8'd74, 8'd82};
            4'd11:   a = {8'd72, 8'd78, 8'd84};
            4'd12:   a = {8'd78, 8'd82, 8'd86};
            4'd13:   a = {8'd84, 8'd86, 8'd88};
            default: a = CENTER_ANGLES;
        endcase
        return a;
    endfunction

    function automatic angles_t right_row(input logic [3:0] r);
        angles_t a;
        case (r)
            4'd0:    a = {8'd90,  8'd90,  8'd90};
            4'd1:    a = {8'd96,  8'd94,  8'd92};
            4'd2:    a = {8'd102, 8'd98,  8'd94};
            4'd3:    a = {8'd108, 8'd102, 8'd96};
            4'd4:    a = {8'd114, 8'd106, 8'd98};
            4'd5:    a = {8'd120, 8'd110, 8'd100};
            4'd6:    a = {8'd120, 8'd110, 8'd100};
            4'd7:    a = {8'd120, 8'd110, 8'd100};
            4'd8:    a = {8'd120, 8'd110, 8'd100};
            4'd9:    a = {8'd120, 8'd110, 8'd100};
            4'd10:   a = {8'd114, 8'd106, 8'd98};
            4'd11:   a = {8'd108, 8'd102, 8'd96};
            4'd12:   a = {8'd102, 8'd98,  8'd94};
            4'd13:   a = {8'd96,  8'd94,  8'd92};
            default: a = CENTER_ANGLES;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/gts_if.sv
// Valid/ready channel interfaces for the sequencer input and result streams.
interface gts_in_if;
    import gts_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gts_out_if;
    import gts_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/gts_cfg.sv
// Configuration register bank, written through a plain indexed write port.
module gts_cfg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output gts_pkg::cfg_t cfg
);
    import gts_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.s_step_period_ms    <= S_PERIOD_RST;
            cfg_reg.turn_step_period_ms <= TURN_PERIOD_RST;
            cfg_reg.obstacle_trigger    <= TRIGGER_RST;
            cfg_reg.obstacle_release    <= RELEASE_RST;
            cfg_reg.rearm_delay_ms      <= COOLDOWN_RST;
            cfg_reg.servo_min_deg       <= SERVO_MIN_RST;
            cfg_reg.servo_max_deg       <= SERVO_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_S_PERIOD:    cfg_reg.s_step_period_ms    <= cfg_data;
                CFG_TURN_PERIOD: cfg_reg.turn_step_period_ms <= cfg_data;
                CFG_TRIGGER:     cfg_reg.obstacle_trigger    <= cfg_data;
                CFG_RELEASE:     cfg_reg.obstacle_release    <= cfg_data;
                CFG_COOLDOWN:    cfg_reg.rearm_delay_ms      <= cfg_data;
                CFG_SERVO_MIN:   cfg_reg.servo_min_deg       <= cfg_data[7:0];
                CFG_SERVO_MAX:   cfg_reg.servo_max_deg       <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/gts_core.sv
// Sequencer state and the combinational update for one item.
module gts_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  gts_pkg::in_item_t  item,
    input  gts_pkg::cfg_t      cfg,
    output gts_pkg::out_item_t result
);
    import gts_pkg::*;

    mode_t       mode_reg,     mode_next;
    mode_t       resume_reg,   resume_next;
    logic [3:0]  row_reg,      row_next;
    logic [31:0] nst_reg,      nst_next;
    logic [15:0] period_reg,   period_next;
    logic [31:0] cool_reg,     cool_next;
    logic        latch_reg,    latch_next;
    angles_t     angles_reg,   angles_next;
    logic        started;
    logic        accepted;

    always_comb
    begin : next_proc
        logic [31:0] cool_diff;
        logic [31:0] step_diff;
        logic        due;
        logic [4:0]  limit;
        logic [3:0]  r;
        logic [4:0]  r_inc;
        angles_t     row;
        logic [7:0]  a;

        mode_next   = mode_reg;
        resume_next = resume_reg;
        row_next    = row_reg;
        nst_next    = nst_reg;
        period_next = period_reg;
        cool_next   = cool_reg;
        latch_next  = latch_reg;
        angles_next = angles_reg;
        started     = 1'b0;
        accepted    = 1'b0;

        cool_diff = item.time_ms - cool_reg;
        step_diff = item.time_ms - nst_reg;
        due       = 1'b0;
        limit     = TURN_ROWS;
        r         = '0;
        r_inc     = '0;
        row       = CENTER_ANGLES;
        a         = item.angle_deg;

        case (opcode_t'(item.opcode))
            OP_TICK:
            begin
                // avoid start: near reading, cooldown over (strictly), latch clear
                if (mode_reg != MODE_AVOID && item.distance != 16'd0 &&
                    item.distance < cfg.obstacle_trigger &&
                    cool_diff != 32'd0 && !cool_diff[31] && !latch_reg)
                begin
                    resume_next = (mode_reg == MODE_CL || mode_reg == MODE_CR) ?
                                  MODE_IDLE : mode_reg;
                    mode_next   = MODE_AVOID;
                    row_next    = '0;
                    period_next = cfg.turn_step_period_ms;
                    nst_next    = '0;
                    latch_next  = 1'b1;
                    started     = 1'b1;
                end
                if (mode_next == MODE_AVOID && item.distance > cfg.obstacle_release)
                begin
                    latch_next = 1'b0;
                end

                // a fresh start compares against a step time of zero
                due = started ? ~item.time_ms[31] : ~step_diff[31];

                if (mode_next == MODE_S || mode_next == MODE_CL ||
                    mode_next == MODE_CR || mode_next == MODE_AVOID)
                begin
                    if (due)
                    begin
                        limit = (mode_next == MODE_S) ? S_ROWS : TURN_ROWS;
                        r     = ({1'b0, row_next} < limit) ? row_next : 4'd0;
                        case (mode_next)
                            MODE_S:  row = wave_row(r);
                            MODE_CR: row = right_row(r);
                            default: row = left_row(r);
                        endcase
                        angles_next = row;
                        r_inc       = {1'b0, r} + 5'd1;
                        row_next    = r_inc[3:0];
                        nst_next    = item.time_ms + {16'd0, period_next};
                        if (r_inc >= limit)
                        begin
                            row_next = '0;
                            if (mode_next == MODE_CL || mode_next == MODE_CR)
                            begin
                                mode_next = MODE_IDLE;
                            end
                            else if (mode_next == MODE_AVOID)
                            begin
                                mode_next = resume_next;
                                cool_next = item.time_ms + {16'd0, cfg.rearm_delay_ms};
                            end
                        end
                    end
                end
                else if (mode_next == MODE_IDLE)
                begin
                    angles_next = CENTER_ANGLES;
                end
            end

            OP_CMD:
            begin
                case (item.command_code)
                    CMD_S:
                    begin
                        mode_next   = MODE_S;
                        row_next    = '0;
                        period_next = cfg.s_step_period_ms;
                        nst_next    = '0;
                    end
                    CMD_LEFT:
                    begin
                        mode_next   = MODE_CL;
                        row_next    = '0;
                        period_next = cfg.turn_step_period_ms;
                        nst_next    = '0;
                    end
                    CMD_RIGHT:
                    begin
                        mode_next   = MODE_CR;
                        row_next    = '0;
                        period_next = cfg.turn_step_period_ms;
                        nst_next    = '0;
                    end
                    CMD_STOP:
                    begin
                        mode_next   = MODE_IDLE;
                        angles_next = CENTER_ANGLES;
                    end
                    CMD_MANUAL:
                    begin
                        mode_next = MODE_MANUAL;
                    end
                    default: ;
                endcase
            end

            OP_WRITE:
            begin
                // clamp to min, else max, then hard cap at 180
                if (item.angle_deg < cfg.servo_min_deg)
                begin
                    a = cfg.servo_min_deg;
                end
                else if (item.angle_deg > cfg.servo_max_deg)
                begin
                    a = cfg.servo_max_deg;
                end
                if (a > MAX_DEG)
                begin
                    a = MAX_DEG;
                end
                case (item.servo_id)
                    SERVO_TAIL:
                    begin
                        angles_next.tail = a;
                        mode_next        = MODE_MANUAL;
                        accepted         = 1'b1;
                    end
                    SERVO_MIDDLE:
                    begin
                        angles_next.middle = a;
                        mode_next          = MODE_MANUAL;
                        accepted           = 1'b1;
                    end
                    SERVO_HEAD:
                    begin
                        angles_next.head = a;
                        mode_next        = MODE_MANUAL;
                        accepted         = 1'b1;
                    end
                    default: ;
                endcase
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            resume_reg <= MODE_IDLE;
            row_reg    <= '0;
            nst_reg    <= '0;
            period_reg <= S_PERIOD_RST;
            cool_reg   <= '0;
            latch_reg  <= 1'b0;
            angles_reg <= CENTER_ANGLES;
        end
        else if (en)
        begin
            mode_reg   <= mode_next;
            resume_reg <= resume_next;
            row_reg    <= row_next;
            nst_reg    <= nst_next;
            period_reg <= period_next;
            cool_reg   <= cool_next;
            latch_reg  <= latch_next;
            angles_reg <= angles_next;
        end
    end

    assign result.tail_angle     = angles_next.tail;
    assign result.middle_angle   = angles_next.middle;
    assign result.head_angle     = angles_next.head;
    assign result.current_mode   = mode_next;
    assign result.avoid_started  = started;
    assign result.write_accepted = accepted;

endmodule

>>> hw/rtl/gait_table_sequencer_with_avoid_top.sv
// Top level of the three-servo gait sequencer: input stage, core, result register.
//
// Items (ticks, mode commands, manual servo writes) arrive on in_ch and each
// produces exactly one result on out_ch, in order. Both channels transfer on
// a clock edge with valid and ready high. Configuration registers are written
// through cfg_we / cfg_index / cfg_data, one register per write. The user must
// write them only while no item is in flight; the block does not enforce this.
//
// An item transferred on in_ch is registered at the input stage, processed
// against the sequencer state, and its result is registered in the result
// register that drives out_ch.
// Throughput: one item per cycle while out_ch.ready is high. The limit is the
// state update loop, which does one item's compare, table lookup and step-time add.
//
// Reset (rst_n low, asynchronous) clears both stages, puts the sequencer in
// idle with all servos at 90 degrees and loads the default configuration.
// When the receiver holds out_ch.ready low the result holds, one more item
// is taken into the input stage, and then in_ch.ready drops until the
// result is taken.
module gait_table_sequencer_with_avoid_top
(
    input  logic        clk,
    input  logic        rst_n,
    gts_in_if.sink      in_ch,
    gts_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gts_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      fire;
    cfg_t      cfg;
    out_item_t result;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign fire        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    gts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gts_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

endmodule
